### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check that holds at every clock edge out of reset
`define GTCD_CHECK(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("gtcd check failed");

// Condition in this cycle implies a condition in the next one
`define GTCD_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gtcd sequence check failed");

`endif

### sv/gtcd_pkg.sv
package gtcd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_PRIME,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_ANGLE,
        CMD_TRACK,
        CMD_CAL,
        CMD_SQUARE,
        CMD_CONFIG
    } t_cmd;

    typedef enum logic [3:0] {
        PS_LOOK,
        PS_SAWP,
        PS_SAWT,
        PS_INT,
        PS_FR1,
        PS_FR2,
        PS_SIGN,
        PS_NUM,
        PS_SPACE,
        PS_KW,
        PS_SP2,
        PS_END
    } t_ps;

    typedef enum logic [1:0] {
        KW_ARM,
        KW_DIST,
        KW_SHOW
    } t_kw;

    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_ANGLE  = 4'd1;
    localparam logic [3:0] ACT_RESET  = 4'd2;
    localparam logic [3:0] ACT_INFO   = 4'd3;
    localparam logic [3:0] ACT_CALIB  = 4'd4;
    localparam logic [3:0] ACT_SQUARE = 4'd5;
    localparam logic [3:0] ACT_CONFIG = 4'd6;
    localparam logic [3:0] ACT_TRACK  = 4'd7;
    localparam logic [3:0] ACT_STOPD  = 4'd8;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_BUSY    = 3'd1;
    localparam logic [2:0] ERR_SQ_RNG  = 3'd2;
    localparam logic [2:0] ERR_SQ_FMT  = 3'd3;
    localparam logic [2:0] ERR_ARM_RNG = 3'd4;
    localparam logic [2:0] ERR_DST_RNG = 3'd5;
    localparam logic [2:0] ERR_CFG_FMT = 3'd6;

    localparam logic [2:0] CAL_CP  = 3'd1;
    localparam logic [2:0] CAL_CPP = 3'd2;
    localparam logic [2:0] CAL_CPM = 3'd3;
    localparam logic [2:0] CAL_CT  = 3'd4;
    localparam logic [2:0] CAL_CTP = 3'd5;
    localparam logic [2:0] CAL_CTM = 3'd6;

    localparam logic [1:0] KIND_ARM  = 2'd1;
    localparam logic [1:0] KIND_DIST = 2'd2;
    localparam logic [1:0] KIND_SHOW = 2'd3;

    localparam logic [2:0] REG_PAN_MIN  = 3'd0;
    localparam logic [2:0] REG_PAN_MAX  = 3'd1;
    localparam logic [2:0] REG_TILT_MIN = 3'd2;
    localparam logic [2:0] REG_TILT_MAX = 3'd3;
    localparam logic [2:0] REG_SQ_DEF   = 3'd4;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] ANGLE_HOME = 16'd900;
    localparam logic [15:0] UNSET      = 16'hFFFF;
    localparam logic [15:0] STEP_DEF   = 16'd5;
    localparam logic [15:0] TRACK_LIM  = 16'd100;
    localparam logic [15:0] SQ_MAX     = 16'd100;
    localparam logic [15:0] ARM_MAX    = 16'd50;
    localparam logic [15:0] DIST_MIN   = 16'd10;
    localparam logic [15:0] DIST_MAX   = 16'd200;

    function automatic logic [7:0] kw_char(t_kw k, logic [1:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            KW_ARM: begin
                unique case (i)
                    2'd0: ch = "A";
                    2'd1: ch = "R";
                    2'd2: ch = "M";
                    default: ch = 8'h00;
                endcase
            end
            KW_DIST: begin
                unique case (i)
                    2'd0: ch = "D";
                    2'd1: ch = "I";
                    2'd2: ch = "S";
                    default: ch = "T";
                endcase
            end
            KW_SHOW: begin
                unique case (i)
                    2'd0: ch = "S";
                    2'd1: ch = "H";
                    2'd2: ch = "O";
                    default: ch = "W";
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [1:0] kw_last(t_kw k);
        return (k == KW_ARM) ? 2'd2 : 2'd3;
    endfunction

endpackage

### sv/gtcd_ram.sv
module gtcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/gimbal_text_command_decoder.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+--------------------------------
// input    | in        | i_valid / o_stall      | i_rx_byte, i_drawing_busy
// result   | out       | o_valid / i_stall      | o_action ... o_param_value
// config   | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// A byte other than CR/LF is stored if there is room. A line end starts the decoder,
// which reads the stored line from its RAM one character per cycle.
// Exact-match commands and busy lines skip the character scan.
// Input is stalled while decoding and while a result waits on i_stall.
// Synchronous active-low reset clears line length and settings; the RAM is not cleared.
module gimbal_text_command_decoder
    import gtcd_pkg::*;
#(
    parameter int LINE_BYTES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_drawing_busy,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [3:0]         o_action,
    output logic [2:0]         o_error_code,
    output logic [15:0]        o_pan_target,
    output logic [15:0]        o_tilt_target,
    output logic               o_scan_on,
    output logic [2:0]         o_calib_mode,
    output logic [15:0]        o_calib_step,
    output logic signed [10:0] o_pan_delta,
    output logic signed [10:0] o_tilt_delta,
    output logic [6:0]         o_square_size,
    output logic [1:0]         o_param_kind,
    output logic [7:0]         o_param_value,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [10:0]        i_cfg_data
);
    localparam int LW = $clog2(LINE_BYTES);
    localparam logic [LW-1:0] LEN_MAX = LW'(LINE_BYTES - 1);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    t_ps    r_ps, n_ps;
    t_kw    r_kw, n_kw;

    logic [10:0] r_pan_min, r_pan_max, r_tilt_min, r_tilt_max;
    logic [6:0]  r_sq_def;

    logic [LW-1:0] r_len, n_len, r_clen, n_clen, r_pos, n_pos, r_dpos, n_dpos;
    logic          r_zero, n_zero;
    logic [7:0]    r_head [0:5];
    logic          r_busy, n_busy;

    logic [15:0] r_pan, n_pan, r_tilt, n_tilt, r_cstep, n_cstep, r_acc, n_acc;
    logic        r_scan, n_scan;
    logic [2:0]  r_cmode, n_cmode;
    logic [6:0]  r_sq, n_sq;
    logic [1:0]  r_kind, n_kind, r_kcnt, n_kcnt;
    logic [7:0]  r_val, n_val;
    logic        r_key, n_key, r_neg, n_neg;
    logic signed [10:0] r_pd, n_pd, r_td, n_td;
    logic [3:0]  r_act, n_act;
    logic [2:0]  r_err, n_err;
    logic        r_ovalid, n_ovalid;

    logic        in_acc, out_acc, eol;
    logic [7:0]  rdata, ch;
    logic        isd;
    logic [15:0] dig, acc_x10, acc10;
    logic        m_stop, m_scan, m_rst, m_info, m_cp, m_ct, m_track, m_sq, m_cfg;
    logic        m_cpp, m_cpm, m_ctp, m_ctm, immediate, run_end;
    t_ps         look_ps;
    logic        fin_en;
    logic [15:0] fin_val, fin_clamp, lo16, hi16;
    logic [15:0] trk_m16;
    logic [6:0]  trk_m;
    logic signed [10:0] trk_v;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = r_ovalid && !i_stall;
    assign eol     = (i_rx_byte == CH_CR) || (i_rx_byte == CH_LF);

    gtcd_ram #(.WIDTH(8), .DEPTH(LINE_BYTES)) u_line (
        .i_clk  (i_clk),
        .i_we   (in_acc && !eol && (r_len < LEN_MAX)),
        .i_waddr(r_len),
        .i_wdata(i_rx_byte),
        .i_raddr(r_pos),
        .o_rdata(rdata)
    );

    // Header matches from the first six characters and the effective length
    always_comb begin
        m_stop  = (r_clen == LW'(4)) && r_head[0] == "S" && r_head[1] == "T"
                  && r_head[2] == "O" && r_head[3] == "P";
        m_scan  = (r_clen == LW'(4)) && r_head[0] == "S" && r_head[1] == "C"
                  && r_head[2] == "A" && r_head[3] == "N";
        m_rst   = (r_clen == LW'(3)) && r_head[0] == "R" && r_head[1] == "S"
                  && r_head[2] == "T";
        m_info  = (r_clen == LW'(4)) && r_head[0] == "I" && r_head[1] == "N"
                  && r_head[2] == "F" && r_head[3] == "O";
        m_cp    = (r_clen == LW'(2)) && r_head[0] == "C" && r_head[1] == "P";
        m_ct    = (r_clen == LW'(2)) && r_head[0] == "C" && r_head[1] == "T";
        m_cpp   = (r_clen >= LW'(3)) && r_head[0] == "C" && r_head[1] == "P"
                  && r_head[2] == CH_PLUS;
        m_cpm   = (r_clen >= LW'(3)) && r_head[0] == "C" && r_head[1] == "P"
                  && r_head[2] == CH_MINUS;
        m_ctp   = (r_clen >= LW'(3)) && r_head[0] == "C" && r_head[1] == "T"
                  && r_head[2] == CH_PLUS;
        m_ctm   = (r_clen >= LW'(3)) && r_head[0] == "C" && r_head[1] == "T"
                  && r_head[2] == CH_MINUS;
        m_track = (r_clen >= LW'(6)) && r_head[0] == "T" && r_head[1] == "R"
                  && r_head[2] == "A" && r_head[3] == "C" && r_head[4] == "K"
                  && r_head[5] == CH_COMMA;
        m_sq    = (r_clen >= LW'(6)) && r_head[0] == "S" && r_head[1] == "Q"
                  && r_head[2] == "U" && r_head[3] == "A" && r_head[4] == "R"
                  && r_head[5] == "E";
        m_cfg   = (r_clen >= LW'(6)) && r_head[0] == "C" && r_head[1] == "O"
                  && r_head[2] == "N" && r_head[3] == "F" && r_head[4] == "I"
                  && r_head[5] == "G";
        immediate = r_busy || (!m_track && (m_scan || m_stop || m_rst || m_info
                    || m_cp || m_ct));
    end

    // Shared digit unit
    always_comb begin
        ch      = (r_dpos < r_clen) ? rdata : 8'h00;
        isd     = (ch >= CH_ZERO) && (ch <= CH_NINE);
        dig     = {12'd0, 4'(ch - CH_ZERO)};
        acc_x10 = {r_acc[12:0], 3'b000} + {r_acc[14:0], 1'b0};
        acc10   = acc_x10 + dig;
        look_ps = (ch == "P") ? PS_SAWP : ((ch == "T") ? PS_SAWT : PS_LOOK);
        run_end = (r_dpos == r_clen);
        trk_m16 = (r_acc > TRACK_LIM) ? TRACK_LIM : r_acc;
        trk_m   = trk_m16[6:0];
        trk_v   = $signed({1'b0, trk_m, 3'b000} + {3'b000, trk_m, 1'b0});
        if (r_neg) begin
            trk_v = -trk_v;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && eol && (r_len != '0)) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: n_state = immediate ? ST_DONE : ST_PRIME;
            ST_PRIME: n_state = ST_RUN;
            ST_RUN: begin
                if (run_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and settings updates
    always_comb begin
        n_len = r_len; n_clen = r_clen; n_zero = r_zero; n_busy = r_busy;
        n_pos = r_pos; n_dpos = r_dpos; n_cmd = r_cmd; n_ps = r_ps; n_kw = r_kw;
        n_kcnt = r_kcnt; n_key = r_key; n_neg = r_neg; n_acc = r_acc;
        n_pan = r_pan; n_tilt = r_tilt; n_scan = r_scan; n_cmode = r_cmode;
        n_cstep = r_cstep; n_sq = r_sq; n_kind = r_kind; n_val = r_val;
        n_pd = r_pd; n_td = r_td; n_act = r_act; n_err = r_err;
        n_ovalid = r_ovalid;
        fin_en = 1'b0;
        fin_val = r_acc;

        if (out_acc) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (eol) begin
                        n_busy = i_drawing_busy;
                        n_len  = '0;
                    end else if (r_len < LEN_MAX) begin
                        n_len = r_len + LW'(1);
                        if (!r_zero) begin
                            if (i_rx_byte == 8'h00) begin
                                n_zero = 1'b1;
                            end else begin
                                n_clen = r_clen + LW'(1);
                            end
                        end
                    end
                end
            end
            ST_CLASS: begin
                n_act = ACT_NONE; n_err = ERR_OK; n_pd = '0; n_td = '0;
                n_acc = '0; n_neg = 1'b0; n_key = 1'b0;
                n_len = '0; n_zero = 1'b0; n_clen = '0;
                n_cmd = CMD_ANGLE; n_ps = PS_LOOK; n_pos = '0;
                priority if (r_busy) begin
                    if (m_stop) n_act = ACT_STOPD;
                    else        n_err = ERR_BUSY;
                end else if (m_track) begin
                    n_cmd = CMD_TRACK; n_ps = PS_SIGN; n_pos = LW'(6);
                end else if (m_scan) begin
                    n_scan = 1'b1; n_act = ACT_ANGLE;
                end else if (m_stop) begin
                    n_scan = 1'b0; n_act = ACT_ANGLE;
                end else if (m_rst) begin
                    n_scan = 1'b0; n_pan = ANGLE_HOME; n_tilt = ANGLE_HOME;
                    n_act = ACT_RESET;
                end else if (m_info) begin
                    n_act = ACT_INFO;
                end else if (m_cp) begin
                    n_cmode = CAL_CP; n_act = ACT_CALIB;
                end else if (m_ct) begin
                    n_cmode = CAL_CT; n_act = ACT_CALIB;
                end else if (m_cpp || m_cpm || m_ctp || m_ctm) begin
                    n_cmd = CMD_CAL; n_ps = PS_NUM; n_pos = LW'(3);
                    n_cmode = m_cpp ? CAL_CPP : (m_cpm ? CAL_CPM
                              : (m_ctp ? CAL_CTP : CAL_CTM));
                end else if (m_sq) begin
                    n_cmd = CMD_SQUARE; n_ps = PS_SPACE; n_pos = LW'(6);
                    n_sq = r_sq_def;
                end else if (m_cfg) begin
                    n_cmd = CMD_CONFIG; n_ps = PS_SPACE; n_pos = LW'(6);
                end
                // clen survives until the scan ends
                n_clen = r_clen;
            end
            ST_PRIME: begin
                n_dpos = r_pos;
                n_pos  = r_pos + LW'(1);
            end
            ST_RUN: begin
                n_dpos = r_pos;
                n_pos  = r_pos + LW'(1);
                unique case (r_cmd)
                    CMD_ANGLE: begin
                        unique case (r_ps)
                            PS_SAWP, PS_SAWT: begin
                                if (ch == CH_EQ) begin
                                    n_ps = PS_INT; n_acc = '0;
                                    n_key = (r_ps == PS_SAWT);
                                end else begin
                                    n_ps = look_ps;
                                end
                            end
                            PS_INT: begin
                                if (isd) begin
                                    n_acc = acc10;
                                end else if (ch == CH_DOT) begin
                                    n_acc = acc_x10; n_ps = PS_FR1;
                                end else begin
                                    fin_en = 1'b1; fin_val = acc_x10; n_ps = look_ps;
                                end
                            end
                            PS_FR1: begin
                                if (isd) begin
                                    n_acc = r_acc + dig; n_ps = PS_FR2;
                                end else begin
                                    fin_en = 1'b1; n_ps = look_ps;
                                end
                            end
                            PS_FR2: begin
                                fin_en = 1'b1;
                                if (isd) begin
                                    fin_val = r_acc + {15'd0, (dig >= 16'd5)};
                                    n_ps = PS_LOOK;
                                end else begin
                                    n_ps = look_ps;
                                end
                            end
                            default: n_ps = look_ps;
                        endcase
                        if (run_end && (n_pan != r_pan || n_tilt != r_tilt || fin_en
                            || r_act == ACT_ANGLE)) begin
                            n_act = r_act;
                        end
                    end
                    CMD_TRACK: begin
                        if (r_ps != PS_END) begin
                            if (r_ps == PS_SIGN && ch == CH_MINUS) begin
                                n_neg = 1'b1; n_ps = PS_NUM;
                            end else if (isd) begin
                                n_acc = acc10; n_ps = PS_NUM;
                            end else begin
                                if (r_key) n_td = trk_v;
                                else       n_pd = trk_v;
                                n_acc = '0; n_neg = 1'b0;
                                if (!r_key && ch == CH_COMMA) begin
                                    n_key = 1'b1; n_ps = PS_SIGN;
                                end else begin
                                    n_ps = PS_END;
                                end
                            end
                        end
                        n_act = ACT_TRACK;
                    end
                    CMD_CAL: begin
                        if (r_ps == PS_NUM) begin
                            if (isd) begin
                                n_acc = acc10;
                            end else begin
                                n_cstep = (r_acc == '0) ? STEP_DEF : r_acc;
                                n_ps = PS_END;
                            end
                        end
                        n_act = ACT_CALIB;
                    end
                    CMD_SQUARE: begin
                        unique case (r_ps)
                            PS_SPACE: begin
                                if (ch == CH_SPACE) begin
                                    n_ps = PS_SPACE;
                                end else if (isd) begin
                                    n_acc = acc10; n_ps = PS_NUM;
                                end else if (ch == 8'h00) begin
                                    n_act = ACT_SQUARE; n_ps = PS_END;
                                end else begin
                                    n_err = ERR_SQ_FMT; n_ps = PS_END;
                                end
                            end
                            PS_NUM: begin
                                if (isd) begin
                                    n_acc = acc10;
                                end else begin
                                    if (r_acc == '0 || r_acc > SQ_MAX) begin
                                        n_err = ERR_SQ_RNG;
                                    end else begin
                                        n_sq = r_acc[6:0]; n_act = ACT_SQUARE;
                                    end
                                    n_ps = PS_END;
                                end
                            end
                            default: n_ps = PS_END;
                        endcase
                    end
                    CMD_CONFIG: begin
                        unique case (r_ps)
                            PS_SPACE: begin
                                n_kcnt = 2'd1;
                                priority if (ch == CH_SPACE) begin
                                    n_ps = PS_SPACE;
                                end else if (ch == "A") begin
                                    n_kw = KW_ARM; n_ps = PS_KW;
                                end else if (ch == "D") begin
                                    n_kw = KW_DIST; n_ps = PS_KW;
                                end else if (ch == "S") begin
                                    n_kw = KW_SHOW; n_ps = PS_KW;
                                end else begin
                                    n_err = ERR_CFG_FMT; n_ps = PS_END;
                                end
                            end
                            PS_KW: begin
                                if (ch != kw_char(r_kw, r_kcnt)) begin
                                    n_err = ERR_CFG_FMT; n_ps = PS_END;
                                end else if (r_kcnt == kw_last(r_kw)) begin
                                    if (r_kw == KW_SHOW) begin
                                        n_kind = KIND_SHOW; n_act = ACT_CONFIG;
                                        n_ps = PS_END;
                                    end else begin
                                        n_ps = PS_SP2;
                                    end
                                end else begin
                                    n_kcnt = r_kcnt + 2'd1;
                                end
                            end
                            PS_SP2, PS_NUM: begin
                                if (r_ps == PS_SP2 && ch == CH_SPACE) begin
                                    n_ps = PS_SP2;
                                end else if (isd) begin
                                    n_acc = acc10; n_ps = PS_NUM;
                                end else begin
                                    n_ps = PS_END;
                                    if (r_kw == KW_ARM) begin
                                        if (r_acc == '0 || r_acc > ARM_MAX) begin
                                            n_err = ERR_ARM_RNG;
                                        end else begin
                                            n_kind = KIND_ARM; n_val = r_acc[7:0];
                                            n_act = ACT_CONFIG;
                                        end
                                    end else begin
                                        if (r_acc < DIST_MIN || r_acc > DIST_MAX) begin
                                            n_err = ERR_DST_RNG;
                                        end else begin
                                            n_kind = KIND_DIST; n_val = r_acc[7:0];
                                            n_act = ACT_CONFIG;
                                        end
                                    end
                                end
                            end
                            default: n_ps = PS_END;
                        endcase
                    end
                    default: n_ps = PS_END;
                endcase
            end
            ST_DONE: begin
                n_ovalid = 1'b1;
                n_clen = '0;
            end
            default: n_ovalid = r_ovalid;
        endcase

        // Angle clamp, shared by pan and tilt
        lo16 = r_key ? {5'd0, r_tilt_min} : {5'd0, r_pan_min};
        hi16 = r_key ? {5'd0, r_tilt_max} : {5'd0, r_pan_max};
        if ($signed(fin_val) < $signed(lo16)) begin
            fin_clamp = lo16;
        end else if ($signed(fin_val) > $signed(hi16)) begin
            fin_clamp = hi16;
        end else begin
            fin_clamp = fin_val;
        end
        if (r_state == ST_RUN && r_cmd == CMD_ANGLE && fin_en) begin
            if (r_key) n_tilt = fin_clamp;
            else       n_pan  = fin_clamp;
            n_act = ACT_ANGLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len <= '0; r_clen <= '0; r_zero <= 1'b0; r_ovalid <= 1'b0;
            r_pan <= UNSET; r_tilt <= UNSET; r_scan <= 1'b0; r_cmode <= '0;
            r_cstep <= '0; r_sq <= '0; r_kind <= '0; r_val <= '0;
            r_pan_min <= 11'd0; r_pan_max <= 11'd1800;
            r_tilt_min <= 11'd0; r_tilt_max <= 11'd1800; r_sq_def <= 7'd10;
            r_act <= ACT_NONE; r_err <= ERR_OK; r_pd <= '0; r_td <= '0;
        end else begin
            r_state <= n_state;
            r_len <= n_len; r_clen <= n_clen; r_zero <= n_zero; r_ovalid <= n_ovalid;
            r_pan <= n_pan; r_tilt <= n_tilt; r_scan <= n_scan; r_cmode <= n_cmode;
            r_cstep <= n_cstep; r_sq <= n_sq; r_kind <= n_kind; r_val <= n_val;
            r_act <= n_act; r_err <= n_err; r_pd <= n_pd; r_td <= n_td;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_PAN_MIN:  r_pan_min  <= i_cfg_data;
                    REG_PAN_MAX:  r_pan_max  <= i_cfg_data;
                    REG_TILT_MIN: r_tilt_min <= i_cfg_data;
                    REG_TILT_MAX: r_tilt_max <= i_cfg_data;
                    REG_SQ_DEF:   r_sq_def   <= i_cfg_data[6:0];
                    default:      r_sq_def   <= r_sq_def;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_busy <= n_busy; r_pos <= n_pos; r_dpos <= n_dpos; r_cmd <= n_cmd;
        r_ps <= n_ps; r_kw <= n_kw; r_kcnt <= n_kcnt; r_key <= n_key;
        r_neg <= n_neg; r_acc <= n_acc;
        if (r_state == ST_IDLE && in_acc && !eol && (r_len < LW'(6))) begin
            r_head[r_len[2:0]] <= i_rx_byte;
        end
    end

    assign o_stall       = (r_state != ST_IDLE) || r_ovalid;
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_ovalid;
    assign o_action      = r_act;
    assign o_error_code  = r_err;
    assign o_pan_target  = r_pan;
    assign o_tilt_target = r_tilt;
    assign o_scan_on     = r_scan;
    assign o_calib_mode  = r_cmode;
    assign o_calib_step  = r_cstep;
    assign o_pan_delta   = r_pd;
    assign o_tilt_delta  = r_td;
    assign o_square_size = r_sq;
    assign o_param_kind  = r_kind;
    assign o_param_value = r_val;

`include "assert_macros.svh"

    `GTCD_NEXT(a_done_shows, r_state == ST_DONE, r_ovalid)
    `GTCD_CHECK(a_valid_idle, !r_ovalid || r_state == ST_IDLE)
    `GTCD_CHECK(a_clen_le_len, r_state != ST_IDLE || r_clen <= r_len)
    `GTCD_CHECK(a_delta_track, !r_ovalid || r_act == ACT_TRACK || (r_pd == '0 && r_td == '0))

endmodule

### bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gtcd_pkg::*;

    localparam int  LINE_MAX    = 31;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  DRAIN_WAIT  = 60;

    typedef struct {
        logic [3:0]         act;
        logic [2:0]         err;
        logic [15:0]        pan;
        logic [15:0]        tilt;
        logic               scan;
        logic [2:0]         cmode;
        logic [15:0]        cstep;
        logic signed [10:0] pdelta;
        logic signed [10:0] tdelta;
        logic [6:0]         sq;
        logic [1:0]         pkind;
        logic [7:0]         pval;
    } cmd_result_t;

    typedef struct {
        logic [7:0] data;
        logic       busy;
    } rx_char_t;

    typedef struct {
        string      text;
        bit         busy;
        bit         typed;
        logic [3:0] act;
        logic [2:0] err;
    } line_row_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_drawing_busy = 1'b0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [3:0]         o_action;
    logic [2:0]         o_error_code;
    logic [15:0]        o_pan_target;
    logic [15:0]        o_tilt_target;
    logic               o_scan_on;
    logic [2:0]         o_calib_mode;
    logic [15:0]        o_calib_step;
    logic signed [10:0] o_pan_delta;
    logic signed [10:0] o_tilt_delta;
    logic [6:0]         o_square_size;
    logic [1:0]         o_param_kind;
    logic [7:0]         o_param_value;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index = '0;
    logic [10:0]        i_cfg_data = '0;

    gimbal_text_command_decoder u_top (.*);

    always #10 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  line_buf [LINE_MAX];
    int          line_len;
    int          cur_len;
    logic [15:0] st_pan, st_tilt, st_cstep;
    logic        st_scan;
    logic [2:0]  st_cmode;
    logic [6:0]  st_sq;
    logic [1:0]  st_pkind;
    logic [7:0]  st_pval;
    logic [15:0] lim_pan_min, lim_pan_max, lim_tilt_min, lim_tilt_max;
    logic [6:0]  sq_default;

    cmd_result_t expected_q[$];
    cmd_result_t last_decoded;
    rx_char_t    rx_q[$];
    rx_char_t    rx_next;
    int          fails = 0;
    int          bytes_sent = 0;
    int          cycles = 0;
    logic        hold = 1'b0;
    logic        quiet = 1'b0;

    function automatic logic [7:0] ch_at(int i);
        return (i < cur_len) ? line_buf[i] : 8'h00;
    endfunction

    function automatic bit is_dig(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit text_at(int p, string s);
        for (int i = 0; i < s.len(); i++)
            if (ch_at(p + i) != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit line_is(string s);
        return text_at(0, s) && cur_len == s.len();
    endfunction

    function automatic logic [15:0] get_num(ref int p);
        logic [15:0] v;
        v = '0;
        while (is_dig(ch_at(p))) begin
            v = v * 16'd10 + 16'(ch_at(p) - CH_ZERO);
            p++;
        end
        return v;
    endfunction

    function automatic logic [15:0] get_angle(ref int p, input logic [15:0] lo, hi);
        logic [15:0] whole;
        logic [15:0] raw;
        int          tenth;
        int          s;
        whole = get_num(p);
        tenth = 0;
        if (ch_at(p) == CH_DOT) begin
            p++;
            if (is_dig(ch_at(p))) begin
                tenth = ch_at(p) - CH_ZERO;
                p++;
            end
            if (is_dig(ch_at(p))) begin
                if (ch_at(p) - CH_ZERO >= 5) begin
                    tenth++;
                    if (tenth >= 10) begin
                        tenth = 0;
                        whole = whole + 16'd1;
                    end
                end
                p++;
            end
        end
        raw = whole * 16'd10 + 16'(tenth);
        s = int'($signed(raw));
        if (s < int'(lo)) s = lo;
        else if (s > int'(hi)) s = hi;
        return 16'(s);
    endfunction

    function automatic logic signed [10:0] get_offset(ref int p);
        bit          neg;
        logic [15:0] m;
        int          v;
        neg = 1'b0;
        if (ch_at(p) == CH_MINUS) begin
            neg = 1'b1;
            p++;
        end
        m = get_num(p);
        if (m > TRACK_LIM) m = TRACK_LIM;
        v = neg ? -int'(m) * 10 : int'(m) * 10;
        return 11'(v);
    endfunction

    function automatic void decode_line(bit busy);
        cmd_result_t r;
        int          p;
        bit          hit;
        bit          got_p, got_t;
        logic [15:0] pv, tv, n;
        string       cal_word [4];
        logic [2:0]  cal_mode [4];
        cal_word = '{"CP+", "CP-", "CT+", "CT-"};
        cal_mode = '{CAL_CPP, CAL_CPM, CAL_CTP, CAL_CTM};
        r = '{default: '0};
        hit = 1'b0;
        cur_len = 0;
        while (cur_len < line_len && line_buf[cur_len] != 8'h00) cur_len++;
        if (busy) begin
            if (line_is("STOP")) r.act = ACT_STOPD;
            else r.err = ERR_BUSY;
        end else if (text_at(0, "TRACK,")) begin
            p = 6;
            r.pdelta = get_offset(p);
            if (ch_at(p) == CH_COMMA) begin
                p++;
                r.tdelta = get_offset(p);
            end
            r.act = ACT_TRACK;
        end else if (line_is("SCAN")) begin
            st_scan = 1'b1;
            r.act = ACT_ANGLE;
        end else if (line_is("STOP")) begin
            st_scan = 1'b0;
            r.act = ACT_ANGLE;
        end else if (line_is("RST")) begin
            st_scan = 1'b0;
            st_pan = ANGLE_HOME;
            st_tilt = ANGLE_HOME;
            r.act = ACT_RESET;
        end else if (line_is("INFO")) begin
            r.act = ACT_INFO;
        end else if (line_is("CP")) begin
            st_cmode = CAL_CP;
            r.act = ACT_CALIB;
        end else if (line_is("CT")) begin
            st_cmode = CAL_CT;
            r.act = ACT_CALIB;
        end else begin
            for (int k = 0; k < 4; k++) begin
                if (!hit && text_at(0, cal_word[k])) begin
                    hit = 1'b1;
                    p = 3;
                    st_cmode = cal_mode[k];
                    st_cstep = get_num(p);
                    if (st_cstep == 16'd0) st_cstep = STEP_DEF;
                    r.act = ACT_CALIB;
                end
            end
            if (hit) begin
            end else if (text_at(0, "SQUARE")) begin
                p = 6;
                st_sq = sq_default;
                while (ch_at(p) == CH_SPACE) p++;
                if (is_dig(ch_at(p))) begin
                    n = get_num(p);
                    if (n < 16'd1 || n > SQ_MAX) r.err = ERR_SQ_RNG;
                    else begin
                        st_sq = n[6:0];
                        r.act = ACT_SQUARE;
                    end
                end else if (ch_at(p) != 8'h00) r.err = ERR_SQ_FMT;
                else r.act = ACT_SQUARE;
            end else if (text_at(0, "CONFIG")) begin
                p = 6;
                while (ch_at(p) == CH_SPACE) p++;
                if (text_at(p, "ARM")) begin
                    p += 3;
                    while (ch_at(p) == CH_SPACE) p++;
                    n = get_num(p);
                    if (n < 16'd1 || n > ARM_MAX) r.err = ERR_ARM_RNG;
                    else begin
                        st_pkind = KIND_ARM;
                        st_pval = n[7:0];
                        r.act = ACT_CONFIG;
                    end
                end else if (text_at(p, "DIST")) begin
                    p += 4;
                    while (ch_at(p) == CH_SPACE) p++;
                    n = get_num(p);
                    if (n < DIST_MIN || n > DIST_MAX) r.err = ERR_DST_RNG;
                    else begin
                        st_pkind = KIND_DIST;
                        st_pval = n[7:0];
                        r.act = ACT_CONFIG;
                    end
                end else if (text_at(p, "SHOW")) begin
                    st_pkind = KIND_SHOW;
                    r.act = ACT_CONFIG;
                end else r.err = ERR_CFG_FMT;
            end else begin
                got_p = 1'b0;
                got_t = 1'b0;
                pv = '0;
                tv = '0;
                p = 0;
                while (p < cur_len) begin
                    if (text_at(p, "P=")) begin
                        p += 2;
                        pv = get_angle(p, lim_pan_min, lim_pan_max);
                        got_p = 1'b1;
                    end else if (text_at(p, "T=")) begin
                        p += 2;
                        tv = get_angle(p, lim_tilt_min, lim_tilt_max);
                        got_t = 1'b1;
                    end else p++;
                end
                if (got_p) st_pan = pv;
                if (got_t) st_tilt = tv;
                if (got_p || got_t) r.act = ACT_ANGLE;
            end
        end
        r.pan   = st_pan;
        r.tilt  = st_tilt;
        r.scan  = st_scan;
        r.cmode = st_cmode;
        r.cstep = st_cstep;
        r.sq    = st_sq;
        r.pkind = st_pkind;
        r.pval  = st_pval;
        last_decoded = r;
        expected_q.push_back(r);
    endfunction

    function automatic void take_char(logic [7:0] b, logic busy);
        if (b != CH_CR && b != CH_LF) begin
            if (line_len < LINE_MAX) begin
                line_buf[line_len] = b;
                line_len++;
            end
        end else if (line_len != 0) begin
            decode_line(busy);
            line_len = 0;
        end
    endfunction

    function automatic void cmp(string nm, int e, int a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
            fails++;
        end
    endfunction

    function automatic void check_result();
        cmd_result_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result, action %0d", $time, o_action);
            fails++;
        end else begin
            e = expected_q.pop_front();
            cmp("action", e.act, o_action);
            cmp("error_code", e.err, o_error_code);
            cmp("pan_target", e.pan, o_pan_target);
            cmp("tilt_target", e.tilt, o_tilt_target);
            cmp("scan_on", e.scan, o_scan_on);
            cmp("calib_mode", e.cmode, o_calib_mode);
            cmp("calib_step", e.cstep, o_calib_step);
            cmp("pan_delta", e.pdelta, o_pan_delta);
            cmp("tilt_delta", e.tdelta, o_tilt_delta);
            cmp("square_size", e.sq, o_square_size);
            cmp("param_kind", e.pkind, o_param_kind);
            cmp("param_value", e.pval, o_param_value);
        end
    endfunction

    // input side: transfer sampled before this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) take_char(i_rx_byte, i_drawing_busy);
            if (!i_valid || !o_stall) begin
                if (rx_q.size() > 0 && (quiet || $urandom_range(99) >= 38)) begin
                    rx_next = rx_q.pop_front();
                    i_valid <= 1'b1;
                    i_rx_byte <= rx_next.data;
                    i_drawing_busy <= rx_next.busy;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) check_result();
        i_stall <= hold || (!quiet && $urandom_range(99) < 38);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // long receiver hold-off once random lines are queued, then a stretch with no idling
    initial begin
        wait (bytes_sent > 340);
        @(posedge i_clk);
        hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold <= 1'b0;
        repeat (200) @(posedge i_clk);
        quiet <= 1'b1;
        repeat (1500) @(posedge i_clk);
        quiet <= 1'b0;
    end

    task automatic push_char(logic [7:0] c, logic busy);
        rx_char_t t;
        t.data = c;
        t.busy = busy;
        rx_q.push_back(t);
        bytes_sent++;
    endtask

    // '@' stands for a zero byte in the directed lines
    task automatic push_line(string s, bit busy);
        for (int i = 0; i < s.len(); i++)
            push_char((s[i] == "@") ? 8'h00 : s[i], 1'($urandom_range(1)));
        push_char($urandom_range(1) ? CH_CR : CH_LF, busy);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_q.size() != 0 || i_valid || expected_q.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [2:0] idx, logic [10:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_PAN_MIN:  lim_pan_min = 16'(v);
            REG_PAN_MAX:  lim_pan_max = 16'(v);
            REG_TILT_MIN: lim_tilt_min = 16'(v);
            REG_TILT_MAX: lim_tilt_max = 16'(v);
            REG_SQ_DEF:   sq_default = v[6:0];
            default: ;
        endcase
    endtask

    function automatic string num_text();
        return $sformatf("%0d", ($urandom_range(3) == 0) ? $urandom_range(99999)
                                                        : $urandom_range(250));
    endfunction

    function automatic string angle_text();
        string s;
        s = $sformatf("%0d", ($urandom_range(5) == 0) ? $urandom_range(9999)
                                                      : $urandom_range(200));
        if ($urandom_range(1)) begin
            s = {s, "."};
            repeat ($urandom_range(2)) s = {s, $sformatf("%0d", $urandom_range(9))};
        end
        return s;
    endfunction

    function automatic string sign_text();
        return $urandom_range(1) ? "-" : "";
    endfunction

    task automatic push_random_line();
        string s;
        bit    busy;
        int    n;
        busy = ($urandom_range(99) < 12);
        case ($urandom_range(17))
            0:  s = "SCAN";
            1:  s = "STOP";
            2:  s = "RST";
            3:  s = "INFO";
            4:  s = $urandom_range(1) ? "CP" : "CT";
            5, 6: begin
                s = $urandom_range(1) ? "CP" : "CT";
                s = {s, $urandom_range(1) ? "+" : "-"};
                if ($urandom_range(3) != 0) s = {s, num_text()};
            end
            7, 8: begin
                s = {"TRACK,", sign_text(), num_text()};
                if ($urandom_range(3) != 0) s = {s, ",", sign_text(), num_text()};
            end
            9: begin
                s = "SQUARE";
                repeat ($urandom_range(2)) s = {s, " "};
                case ($urandom_range(3))
                    0: ;
                    1: s = {s, "X"};
                    default: s = {s, num_text()};
                endcase
            end
            10, 11: begin
                s = "CONFIG";
                repeat ($urandom_range(2)) s = {s, " "};
                case ($urandom_range(4))
                    0: s = {s, "ARM ", num_text()};
                    1: s = {s, "ARM", $sformatf("%0d", $urandom_range(60))};
                    2: s = {s, "DIST ", num_text()};
                    3: s = {s, "SHOW"};
                    default: s = {s, "SHIFT"};
                endcase
            end
            12, 13, 14: begin
                s = "";
                repeat (1 + $urandom_range(2)) begin
                    s = {s, $urandom_range(1) ? "P=" : "T=", angle_text()};
                    if ($urandom_range(1)) s = {s, " "};
                end
            end
            default: begin
                // raw noise, any byte value
                n = 1 + $urandom_range(($urandom_range(4) == 0) ? 45 : 8);
                for (int i = 0; i < n; i++)
                    push_char(8'($urandom_range(255)), 1'($urandom_range(1)));
                push_char($urandom_range(1) ? CH_CR : CH_LF, busy);
                return;
            end
        endcase
        push_line(s, busy);
        if ($urandom_range(15) == 0) push_char(CH_LF, busy);
    endtask

    line_row_t rows [] = '{
        '{"INFO",              0, 1, ACT_INFO,   ERR_OK},
        '{"SCAN",              0, 1, ACT_ANGLE,  ERR_OK},
        '{"STOP",              0, 1, ACT_ANGLE,  ERR_OK},
        '{"RST",               0, 1, ACT_RESET,  ERR_OK},
        '{"CP",                0, 1, ACT_CALIB,  ERR_OK},
        '{"CT",                0, 1, ACT_CALIB,  ERR_OK},
        '{"CP+0",              0, 1, ACT_CALIB,  ERR_OK},
        '{"CT-65536",          0, 1, ACT_CALIB,  ERR_OK},
        '{"CP-65535",          0, 1, ACT_CALIB,  ERR_OK},
        '{"CT+12",             0, 1, ACT_CALIB,  ERR_OK},
        '{"TRACK,-999,100",    0, 1, ACT_TRACK,  ERR_OK},
        '{"TRACK,",            0, 1, ACT_TRACK,  ERR_OK},
        '{"SQUARE",            0, 1, ACT_SQUARE, ERR_OK},
        '{"SQUARE 0",          0, 1, ACT_NONE,   ERR_SQ_RNG},
        '{"SQUARE 101",        0, 1, ACT_NONE,   ERR_SQ_RNG},
        '{"SQUARE x",          0, 1, ACT_NONE,   ERR_SQ_FMT},
        '{"SQUARE  100 cm",    0, 1, ACT_SQUARE, ERR_OK},
        '{"CONFIG ARM 50",     0, 1, ACT_CONFIG, ERR_OK},
        '{"CONFIG ARM 0",      0, 1, ACT_NONE,   ERR_ARM_RNG},
        '{"CONFIG DIST 9",     0, 1, ACT_NONE,   ERR_DST_RNG},
        '{"CONFIG DIST 200",   0, 1, ACT_CONFIG, ERR_OK},
        '{"CONFIG SHOW",       0, 1, ACT_CONFIG, ERR_OK},
        '{"CONFIG FOO",        0, 1, ACT_NONE,   ERR_CFG_FMT},
        '{"P=180.05 T=3276.8", 0, 0, ACT_NONE,   ERR_OK},
        '{"P=12.96T=9.99 P=5", 0, 0, ACT_NONE,   ERR_OK},
        '{"INFO@P=5",          0, 1, ACT_INFO,   ERR_OK},
        '{"P=1.5 P=2.5 P=3.5 P=4.5 P=5.5 P=66", 0, 0, ACT_NONE, ERR_OK},
        '{"",                  0, 0, ACT_NONE,   ERR_OK},
        '{"STOP",              1, 1, ACT_STOPD,  ERR_OK},
        '{"SCAN",              1, 1, ACT_NONE,   ERR_BUSY}
    };

    initial begin
        line_len = 0;
        cur_len = 0;
        st_pan = UNSET;
        st_tilt = UNSET;
        st_cstep = '0;
        st_scan = 1'b0;
        st_cmode = '0;
        st_sq = '0;
        st_pkind = '0;
        st_pval = '0;
        lim_pan_min = 16'd0;
        lim_pan_max = 16'd1800;
        lim_tilt_min = 16'd0;
        lim_tilt_max = 16'd1800;
        sq_default = 7'd10;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            push_line(rows[i].text, rows[i].busy);
            wait_idle();
            if (rows[i].typed && (last_decoded.act != rows[i].act
                                  || last_decoded.err != rows[i].err)) begin
                $display("%0t: line \"%s\" expected action %0d error %0d, got %0d %0d",
                         $time, rows[i].text, rows[i].act, rows[i].err,
                         last_decoded.act, last_decoded.err);
                fails++;
            end
        end

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    set_reg(REG_PAN_MIN, 11'd0);
                    set_reg(REG_PAN_MAX, 11'd1800);
                    set_reg(REG_TILT_MIN, 11'd0);
                    set_reg(REG_TILT_MAX, 11'd1800);
                    set_reg(REG_SQ_DEF, 11'd100);
                end
                1: begin
                    // pan min above max, tilt min equal to max
                    set_reg(REG_PAN_MIN, 11'd1800);
                    set_reg(REG_PAN_MAX, 11'd0);
                    set_reg(REG_TILT_MIN, 11'd900);
                    set_reg(REG_TILT_MAX, 11'd900);
                    set_reg(REG_SQ_DEF, 11'd1);
                end
                default: begin
                    set_reg(REG_PAN_MIN, 11'($urandom_range(900)));
                    set_reg(REG_PAN_MAX, 11'($urandom_range(1800, 900)));
                    set_reg(REG_TILT_MIN, 11'($urandom_range(900)));
                    set_reg(REG_TILT_MAX, 11'($urandom_range(1800, 900)));
                    set_reg(REG_SQ_DEF, 11'($urandom_range(100, 1)));
                end
            endcase
            while (bytes_sent < 80 * (ph + 1) + 300) push_random_line();
            wait_idle();
        end

        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
